### rtl/mscs_pkg.sv
// mscs_pkg: shared types and constants for the moduli subset cost selector
// no dependencies
`default_nettype none
package mscs_pkg;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_ONE   = 2'd1;
    localparam logic [1:0] MODE_TWO   = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [16:0] LN2_FIX           = 17'd45426;
    localparam logic [6:0]  ADD_WEIGHT        = 7'd100;
    localparam logic [7:0]  DROP_WEIGHT_RESET = 8'd20;
    localparam int          COST_W            = 18;
    localparam int          OUT_IDX_W         = 10;

    // datapath read phases
    typedef enum logic [1:0] {
        RD_NONE,
        RD_LOOK,
        RD_EVAL
    } rd_kind_t;

    // controller to datapath commands
    typedef struct packed {
        logic     load;
        logic     clear;
        logic     capture;
        logic     rd_en;
        rd_kind_t rd_kind;
        logic     reset_best;
        logic     set_ref;
        logic     tie_later;
        logic     emit;
    } dp_cmd_t;

endpackage
`default_nettype wire

### rtl/mscs_datapath.sv
// mscs_datapath: entry tables, query registers, cost unit and best tracking
// depends on mscs_pkg
`default_nettype none
module mscs_datapath #(
    parameter int TABLE_DEPTH = 1024,
    parameter int SET_BITS    = 64,
    parameter int IDX_W       = 10,
    parameter int CNT_W       = 11
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  mscs_pkg::dp_cmd_t        cmd,
    input  wire [IDX_W-1:0]          rd_addr,
    input  wire [7:0]                drop_weight,
    input  wire [1:0]                mode,
    input  wire [31:0]               entry_size,
    input  wire [63:0]               entry_set,
    input  wire [31:0]               window_low,
    input  wire [31:0]               window_high,
    input  wire [63:0]               source_set_a,
    input  wire [63:0]               source_set_b,
    output logic [CNT_W-1:0]         count,
    output logic                     look_ge_low,
    output logic                     eval_le_high,
    output logic                     eval_in_up,
    output logic                     eval_in_down,
    output logic                     eval_valid,
    output logic                     found,
    output logic [SET_BITS-1:0]      best_set,
    output logic [IDX_W-1:0]         best_idx
);
    import mscs_pkg::*;

    logic [31:0]         size_mem [TABLE_DEPTH];
    logic [SET_BITS-1:0] set_mem  [TABLE_DEPTH];
    logic [31:0]         rd_size_reg;
    logic [SET_BITS-1:0] rd_set_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    rd_kind_t            rd_kind_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [31:0]         low_reg, high_reg;
    logic [SET_BITS-1:0] a_reg, b_reg;
    logic                two_reg;
    logic [31:0]         ref_reg;
    logic                found_reg;
    logic [COST_W-1:0]   best_cost_reg;
    logic [SET_BITS-1:0] best_set_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic                tie_later_reg;

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load && count_reg < CNT_W'(TABLE_DEPTH))
        begin
            size_mem[count_reg[IDX_W-1:0]] <= entry_size;
            set_mem[count_reg[IDX_W-1:0]]  <= entry_set[SET_BITS-1:0];
        end
        if (cmd.rd_en)
        begin
            rd_size_reg <= size_mem[rd_addr];
            rd_set_reg  <= set_mem[rd_addr];
        end
    end

    // popcount based cost for one source
    function automatic logic [COST_W-1:0] one_cost(input logic [SET_BITS-1:0] s,
                                                   input logic [SET_BITS-1:0] t,
                                                   input logic [7:0] w);
        logic [6:0] add_n, drop_n;
        add_n  = 7'(($countones(t & ~s)));
        drop_n = 7'(($countones(s & ~t)));
        return COST_W'(add_n * ADD_WEIGHT) + COST_W'(drop_n * w);
    endfunction

    logic [COST_W-1:0] cost;
    logic              better;
    always_comb
    begin
        cost = one_cost(a_reg, rd_set_reg, drop_weight);
        if (two_reg)
            cost = cost + one_cost(b_reg, rd_set_reg, drop_weight);
        if (!found_reg)
            better = 1'b1;
        else if (tie_later_reg)
            better = (cost <= best_cost_reg);
        else
            better = (cost < best_cost_reg);
    end

    // fallback bounds: upward adds ln2 to the reference, downward to the entry
    assign look_ge_low  = rd_size_reg >= low_reg;
    assign eval_le_high = rd_size_reg <= high_reg;
    assign eval_in_up   = {1'b0, rd_size_reg} <= ({1'b0, ref_reg} + 33'(LN2_FIX));
    assign eval_in_down = ({1'b0, rd_size_reg} + 33'(LN2_FIX)) >= {1'b0, ref_reg};
    assign eval_valid   = (rd_kind_reg == RD_EVAL);

    // query state, count and best tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            found_reg   <= 1'b0;
            rd_kind_reg <= RD_NONE;
        end
        else
        begin
            rd_kind_reg <= cmd.rd_en ? cmd.rd_kind : RD_NONE;
            if (cmd.clear)
                count_reg <= '0;
            else if (cmd.load && count_reg < CNT_W'(TABLE_DEPTH))
                count_reg <= count_reg + 1'b1;
            if (cmd.reset_best)
                found_reg <= 1'b0;
            else if (cmd.emit && eval_valid && better)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_idx_reg <= rd_addr;
        if (cmd.capture)
        begin
            low_reg  <= window_low;
            high_reg <= window_high;
            a_reg    <= source_set_a[SET_BITS-1:0];
            b_reg    <= source_set_b[SET_BITS-1:0];
            two_reg  <= (mode == MODE_TWO);
        end
        if (cmd.reset_best)
            tie_later_reg <= cmd.tie_later;
        // size of the fallback reference entry
        if (cmd.set_ref)
            ref_reg <= rd_size_reg;
        if (cmd.emit && eval_valid && better)
        begin
            best_cost_reg <= cost;
            best_set_reg  <= rd_set_reg;
            best_idx_reg  <= rd_idx_reg;
        end
    end

    assign count    = count_reg;
    assign found    = found_reg;
    assign best_set = best_set_reg;
    assign best_idx = best_idx_reg;

endmodule
`default_nettype wire

### rtl/mscs_control.sv
// mscs_control: sequencer for load, clear, start search and scans
// depends on mscs_pkg
`default_nettype none
module mscs_control #(
    parameter int IDX_W = 10,
    parameter int CNT_W = 11
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire [1:0]           mode,
    input  wire                 search_upward,
    input  wire [CNT_W-1:0]     count,
    input  wire                 look_ge_low,
    input  wire                 eval_le_high,
    input  wire                 eval_in_up,
    input  wire                 eval_in_down,
    input  wire                 found,
    output mscs_pkg::dp_cmd_t   cmd,
    output logic [IDX_W-1:0]    rd_addr,
    output logic                busy,
    output logic                done
);
    import mscs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_BS_RD, S_BS_WT, S_WIN_RD, S_WIN_WT,
        S_REF_RD, S_REF_WT, S_FB_RD, S_FB_WT, S_DONE
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] lo_reg, hi_reg, pos_reg, n_reg;
    logic             up_reg, busy_reg, done_reg;

    // commands decoded from state
    always_comb
    begin
        cmd = '0;
        cmd.rd_kind = RD_NONE;
        rd_addr = pos_reg[IDX_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load       = (mode == MODE_LOAD);
                    cmd.clear      = (mode == MODE_CLEAR);
                    cmd.capture    = 1'b1;
                    cmd.reset_best = 1'b1;
                    cmd.tie_later  = 1'b1;
                end
            end
            S_BS_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_kind = RD_LOOK;
            end
            S_WIN_RD, S_FB_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_kind = RD_EVAL;
            end
            S_WIN_WT:
                cmd.emit = eval_le_high;
            S_REF_RD:
                cmd.rd_en = 1'b1;
            S_REF_WT:
            begin
                cmd.set_ref    = 1'b1;
                cmd.tie_later  = 1'b0;
                cmd.reset_best = 1'b1;
            end
            S_FB_WT:
                cmd.emit = up_reg ? eval_in_up : eval_in_down;
            default:
                ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            pos_reg   <= '0;
            n_reg     <= '0;
            up_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start && (mode == MODE_ONE || mode == MODE_TWO))
                    begin
                        n_reg     <= count;
                        lo_reg    <= '0;
                        hi_reg    <= count;
                        pos_reg   <= '0;
                        up_reg    <= search_upward;
                        busy_reg  <= 1'b1;
                        state_reg <= (count == '0) ? S_DONE : S_BS_RD;
                    end
                end
                S_BS_RD:
                    state_reg <= S_BS_WT;
                // window start: first entry from index 0 at or above low
                S_BS_WT:
                begin
                    if (look_ge_low)
                    begin
                        hi_reg    <= pos_reg;
                        state_reg <= S_WIN_RD;
                    end
                    else if (pos_reg + 1'b1 == n_reg)
                    begin
                        pos_reg   <= n_reg;
                        hi_reg    <= n_reg;
                        state_reg <= S_REF_RD;
                    end
                    else
                    begin
                        pos_reg   <= pos_reg + 1'b1;
                        state_reg <= S_BS_RD;
                    end
                end
                S_WIN_RD:
                    state_reg <= S_WIN_WT;
                S_WIN_WT:
                begin
                    if (eval_le_high)
                    begin
                        pos_reg   <= pos_reg + 1'b1;
                        lo_reg    <= pos_reg;
                        state_reg <= (pos_reg + 1'b1 == n_reg) ? S_DONE : S_WIN_RD;
                    end
                    else
                    begin
                        lo_reg    <= pos_reg;
                        state_reg <= found ? S_DONE : S_REF_RD;
                    end
                end
                // fallback reference entry; window scan stop or start-1
                S_REF_RD:
                begin
                    if (found)
                        state_reg <= S_DONE;
                    else if (up_reg)
                    begin
                        if (pos_reg == n_reg)
                            state_reg <= S_DONE;
                        else
                            state_reg <= S_REF_WT;
                    end
                    else if (hi_reg == '0)
                        state_reg <= S_DONE;
                    else
                    begin
                        pos_reg   <= hi_reg - 1'b1;
                        state_reg <= S_REF_RD;
                        hi_reg    <= '0;
                        lo_reg    <= {CNT_W{1'b1}};
                    end
                end
                S_REF_WT:
                    state_reg <= S_FB_RD;
                S_FB_RD:
                    state_reg <= S_FB_WT;
                S_FB_WT:
                begin
                    if (up_reg ? eval_in_up : eval_in_down)
                    begin
                        if (up_reg)
                        begin
                            pos_reg   <= pos_reg + 1'b1;
                            state_reg <= (pos_reg + 1'b1 == n_reg) ? S_DONE : S_FB_RD;
                        end
                        else
                        begin
                            pos_reg   <= pos_reg - 1'b1;
                            state_reg <= (pos_reg == '0) ? S_DONE : S_FB_RD;
                        end
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    busy_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
            // downward: once start-1 is chosen, read it as reference next
            if (state_reg == S_REF_RD && !found && !up_reg && hi_reg != '0)
                state_reg <= S_REF_RD;
            if (state_reg == S_REF_RD && !found && !up_reg && hi_reg == '0
                && lo_reg == {CNT_W{1'b1}})
                state_reg <= S_REF_WT;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

### rtl/moduli_subset_cost_select.sv
// moduli_subset_cost_select: top level, config register and output strobe
// depends on mscs_pkg, mscs_control, mscs_datapath
`default_nettype none
// A load or clear leaves busy low. A query first scans the table from index 0
// for the first entry at or above window_low, one entry at a time through the
// single table read port, then walks the window from that entry. A fallback
// reads the reference entry (downward after first choosing start-1), latches
// the bound, and scans entries including the one that ends the scan. A closing
// state follows, and the result shows in the next cycle for one cycle with
// result_valid and cannot be stalled; busy is high for the whole query and
// start is ignored while it is.
module moduli_subset_cost_select #(
    parameter int TABLE_DEPTH = 1024,
    parameter int SET_BITS    = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire [1:0]   mode,
    input  wire [31:0]  entry_size,
    input  wire [63:0]  entry_set,
    input  wire [31:0]  window_low,
    input  wire [31:0]  window_high,
    input  wire [63:0]  source_set_a,
    input  wire [63:0]  source_set_b,
    input  wire         search_upward,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [7:0]   cfg_data,
    output logic        result_valid,
    output logic [63:0] chosen_set,
    output logic        found,
    output logic [9:0]  chosen_index
);
    import mscs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;

    logic [7:0]          drop_weight_reg;
    dp_cmd_t             cmd;
    logic [IDX_W-1:0]    rd_addr;
    logic [CNT_W-1:0]    count;
    logic                look_ge_low, eval_le_high, eval_in_up, eval_in_down;
    logic                eval_valid, dp_found, done, busy_int;
    logic [SET_BITS-1:0] best_set;
    logic [IDX_W-1:0]    best_idx;
    logic [IDX_W:0]      best_idx_w;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            drop_weight_reg <= DROP_WEIGHT_RESET;
        else if (cfg_valid && cfg_ready)
            drop_weight_reg <= cfg_data;
    end
    assign cfg_ready = 1'b1;

    mscs_control #(.IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start && !busy_int), .mode(mode),
        .search_upward(search_upward), .count(count), .look_ge_low(look_ge_low),
        .eval_le_high(eval_le_high), .eval_in_up(eval_in_up),
        .eval_in_down(eval_in_down), .found(dp_found), .cmd(cmd),
        .rd_addr(rd_addr), .busy(busy_int), .done(done)
    );

    mscs_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .SET_BITS(SET_BITS),
                    .IDX_W(IDX_W), .CNT_W(CNT_W)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .rd_addr(rd_addr),
        .drop_weight(drop_weight_reg), .mode(mode), .entry_size(entry_size),
        .entry_set(entry_set), .window_low(window_low), .window_high(window_high),
        .source_set_a(source_set_a), .source_set_b(source_set_b), .count(count),
        .look_ge_low(look_ge_low), .eval_le_high(eval_le_high),
        .eval_in_up(eval_in_up), .eval_in_down(eval_in_down),
        .eval_valid(eval_valid), .found(dp_found), .best_set(best_set),
        .best_idx(best_idx)
    );

    // result strobe and payload
    assign best_idx_w   = {1'b0, best_idx} & {(IDX_W+1){eval_valid | 1'b1}};
    assign busy         = busy_int;
    assign result_valid = done;
    assign found        = dp_found;
    assign chosen_set   = dp_found ? 64'(best_set) : 64'd0;
    assign chosen_index = dp_found ? OUT_IDX_W'(best_idx_w) : 10'd0;

endmodule
`default_nettype wire

### tb/sv/tb_moduli_subset_cost_select.sv
// tb_moduli_subset_cost_select: self-checking testbench for the moduli subset cost selector
// depends on mscs_pkg and moduli_subset_cost_select; predicts each query result and checks it
`timescale 1ns / 100ps
`default_nettype none
module tb_moduli_subset_cost_select;
    import mscs_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int CYCLE_MAX  = 3000000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] set;
        logic        hit;
        logic [9:0]  idx;
    } pick_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  mode = MODE_LOAD;
    logic [31:0] entry_size = '0;
    logic [63:0] entry_set = '0;
    logic [31:0] window_low = '0;
    logic [31:0] window_high = '0;
    logic [63:0] source_set_a = '0;
    logic [63:0] source_set_b = '0;
    logic        search_upward = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;
    logic        result_valid;
    logic [63:0] chosen_set;
    logic        found;
    logic [9:0]  chosen_index;

    // predictor state
    logic [31:0] tbl_size [DEPTH];
    logic [63:0] tbl_set [DEPTH];
    int          tbl_count;
    logic [7:0]  drop_cost;

    pick_t       pending_picks [$];
    int          errors = 0;
    int          cycles = 0;
    bit          idle_on = 1'b1;
    int          burst_left = 0;

    always #5 clk = ~clk;

    moduli_subset_cost_select u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .entry_size(entry_size), .entry_set(entry_set), .window_low(window_low),
        .window_high(window_high), .source_set_a(source_set_a),
        .source_set_b(source_set_b), .search_upward(search_upward),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .result_valid(result_valid), .chosen_set(chosen_set), .found(found),
        .chosen_index(chosen_index)
    );

    // cost of moving from source set to target set
    function automatic int move_cost(logic [63:0] src, logic [63:0] dst);
        return 100 * $countones(dst & ~src) + int'(drop_cost) * $countones(src & ~dst);
    endfunction

    function automatic int pair_cost(int k, logic [63:0] a, logic [63:0] b, bit two);
        int c;
        c = move_cost(a, tbl_set[k]);
        if (two)
            c += move_cost(b, tbl_set[k]);
        return c;
    endfunction

    // lowest-cost entry in the window, else lowest-cost fallback within ln2
    function automatic pick_t best_pick(logic [31:0] lo, logic [31:0] hi,
                                        logic [63:0] a, logic [63:0] b, bit two, bit up);
        pick_t p;
        int first, k, j, best, best_c, c;
        bit hit;
        longint unsigned bound;
        first = tbl_count;
        hit = 0;
        best = 0;
        best_c = 0;
        for (k = 0; k < tbl_count; k++)
            if (tbl_size[k] >= lo)
            begin
                first = k;
                break;
            end
        for (k = first; k < tbl_count && tbl_size[k] <= hi; k++)
        begin
            c = pair_cost(k, a, b, two);
            if (!hit || c <= best_c)
            begin
                hit = 1;
                best = k;
                best_c = c;
            end
        end
        if (!hit && up && k < tbl_count)
        begin
            bound = longint'(tbl_size[k]) + longint'(LN2_FIX);
            for (j = k; j < tbl_count && longint'(tbl_size[j]) <= bound; j++)
            begin
                c = pair_cost(j, a, b, two);
                if (!hit || c < best_c)
                begin
                    hit = 1;
                    best = j;
                    best_c = c;
                end
            end
        end
        else if (!hit && !up && first > 0)
        begin
            bound = longint'(tbl_size[first-1]);
            for (j = first; j > 0 && longint'(tbl_size[j-1]) + longint'(LN2_FIX) >= bound; j--)
            begin
                c = pair_cost(j - 1, a, b, two);
                if (!hit || c < best_c)
                begin
                    hit = 1;
                    best = j - 1;
                    best_c = c;
                end
            end
        end
        p.hit = hit;
        p.set = hit ? tbl_set[best] : '0;
        p.idx = hit ? best[9:0] : '0;
        return p;
    endfunction

    // send one request and update the prediction when it is taken
    task automatic send(logic [1:0] m, logic [31:0] esz, logic [63:0] est,
                        logic [31:0] lo, logic [31:0] hi, logic [63:0] a,
                        logic [63:0] b, bit up);
        start <= 1'b1;
        mode <= m;
        entry_size <= esz;
        entry_set <= est;
        window_low <= lo;
        window_high <= hi;
        source_set_a <= a;
        source_set_b <= b;
        search_upward <= up;
        do @(posedge clk); while (busy);
        case (m)
            MODE_LOAD:
                if (tbl_count < DEPTH)
                begin
                    tbl_size[tbl_count] = esz;
                    tbl_set[tbl_count] = est;
                    tbl_count++;
                end
            MODE_CLEAR: tbl_count = 0;
            default: pending_picks = {pending_picks, best_pick(lo, hi, a, b, m == MODE_TWO, up)};
        endcase
        // sender bursts and gaps
        if (idle_on)
        begin
            if (burst_left == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 20);
            end
            else
                burst_left--;
        end
    endtask

    task automatic load(logic [31:0] sz, logic [63:0] st);
        send(MODE_LOAD, sz, st, $urandom, $urandom, {$urandom, $urandom},
             {$urandom, $urandom}, $urandom_range(0, 1));
    endtask

    task automatic query(logic [31:0] lo, logic [31:0] hi, logic [63:0] a,
                         logic [63:0] b, bit two, bit up);
        send(two ? MODE_TWO : MODE_ONE, $urandom, {$urandom, $urandom}, lo, hi, a, b, up);
    endtask

    task automatic clear_table();
        send(MODE_CLEAR, $urandom, {$urandom, $urandom}, $urandom, $urandom,
             {$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 1));
    endtask

    // hold off until every expected result is back and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_picks.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_drop_cost(logic [7:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        drop_cost = v;
    endtask

    function automatic logic [63:0] rand_set();
        case ($urandom_range(0, 4))
            0: return {$urandom, $urandom};
            1: return 64'h0F << (4 * $urandom_range(0, 2));
            2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            3: return ALL_ONES;
            default: return 64'(1) << $urandom_range(0, 63);
        endcase
    endfunction

    // result checking
    always @(posedge clk)
    begin
        pick_t want;
        if (rst_n && result_valid)
        begin
            if (pending_picks.size() == 0)
            begin
                $error("result with no pending query");
                errors++;
            end
            else
            begin
                want = pending_picks.pop_front();
                if (chosen_set !== want.set)
                begin
                    $error("chosen_set expected %h actual %h", want.set, chosen_set);
                    errors++;
                end
                if (found !== want.hit)
                begin
                    $error("found expected %b actual %b", want.hit, found);
                    errors++;
                end
                if (chosen_index !== want.idx)
                begin
                    $error("chosen_index expected %0d actual %0d", want.idx, chosen_index);
                    errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_MAX)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // queries on an empty table and default drop cost
    task automatic test_empty();
        query(32'h0, 32'hFFFF_FFFF, ALL_ONES, 64'h0, 1'b0, 1'b0);
        query(32'h0, 32'hFFFF_FFFF, 64'h0, ALL_ONES, 1'b1, 1'b1);
    endtask

    // windows, ties, fallbacks and field extremes
    task automatic test_directed();
        clear_table();
        load(32'h0000_0000, 64'h0F);
        load(32'h0001_0000, 64'h0F);
        load(32'h0001_8000, 64'hF0);
        load(32'h0005_0000, 64'h0F);
        load(32'h0005_4000, 64'h0F);
        load(32'hFFFF_FFFF, ALL_ONES);
        // tie in window: later wins
        query(32'h0, 32'h0001_0000, 64'h0F, 64'h0, 1'b0, 1'b0);
        // empty window below: first of tie within ln2 wins
        query(32'h0005_8000, 32'h0006_0000, 64'h0F, 64'h0, 1'b0, 1'b0);
        // empty window, upward
        query(32'h0002_0000, 32'h0003_0000, 64'h0F, 64'hF0, 1'b1, 1'b1);
        // nothing below the start
        query(32'h0, 32'h0, 64'hF0, 64'h0, 1'b0, 1'b0);
        query(32'h0, 32'h0, ALL_ONES, ALL_ONES, 1'b1, 1'b0);
        // upward at the last entry
        query(32'hFFFF_FFFF, 32'h0, 64'h0, 64'h0, 1'b0, 1'b1);
        query(32'hFFFF_FFFF, 32'hFFFF_FFFF, ALL_ONES, 64'h0, 1'b0, 1'b1);
        // inverted window, both directions
        query(32'h0001_8000, 32'h0001_0000, 64'hF0, 64'h0F, 1'b1, 1'b0);
        query(32'h0001_8000, 32'h0001_0000, 64'hF0, 64'h0F, 1'b1, 1'b1);
        clear_table();
        query(32'h0, 32'hFFFF_FFFF, 64'h0F, 64'h0, 1'b0, 1'b0);
    endtask

    // drop cost extremes change the choice
    task automatic test_drop_cost();
        logic [7:0] v;
        v = 8'd0;
        for (int s = 0; s < 4; s++)
        begin
            if (s == 1)
                v = 8'd255;
            else if (s > 1)
                v = $urandom;
            write_drop_cost(v);
            clear_table();
            load(32'h0001_0000, 64'h01);
            load(32'h0001_1000, 64'h0F);
            load(32'h0001_2000, ALL_ONES);
            query(32'h0, 32'h0002_0000, 64'h07, 64'h0, 1'b0, 1'b0);
            query(32'h0, 32'h0002_0000, 64'h3F, 64'h03, 1'b1, 1'b0);
        end
        write_drop_cost(DROP_WEIGHT_RESET);
    endtask

    // fill past capacity; extra load is dropped
    task automatic test_full_table();
        idle_on = 1'b0;
        clear_table();
        for (int k = 0; k <= DEPTH; k++)
            load(32'(k) * 32'd30000, rand_set());
        idle_on = 1'b1;
        query(32'd0, 32'hFFFF_FFFF, rand_set(), rand_set(), 1'b1, 1'b0);
        query(32'd30000 * 1023, 32'hFFFF_FFFF, rand_set(), 64'h0, 1'b0, 1'b0);
        query(32'd30000 * 1023 + 1, 32'hFFFF_FFFF, rand_set(), 64'h0, 1'b0, 1'b0);
        query(32'd30000 * 500 + 1, 32'd30000 * 500 + 2, rand_set(), 64'h0, 1'b0, 1'b1);
        drain();
    endtask

    // random sorted tables with queries near their entries, plus noise
    task automatic test_random();
        int sent, n;
        logic [31:0] sz, lo, hi;
        logic [31:0] sizes [64];
        sent = 0;
        while (sent < 350)
        begin
            if ($urandom_range(0, 5) == 0)
                write_drop_cost($urandom);
            idle_on = ($urandom_range(0, 3) != 0);
            clear_table();
            n = $urandom_range(0, 40);
            sz = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
            for (int k = 0; k < n; k++)
            begin
                sizes[k] = sz;
                load(sz, rand_set());
                if (sz < 32'hFFF0_0000)
                    sz += $urandom_range(0, 70000);
            end
            sent += n + 1;
            for (int q = 0; q < 20; q++)
            begin
                case ($urandom_range(0, 9))
                    0: load($urandom, rand_set());
                    1: send(MODE_CLEAR, $urandom, {$urandom, $urandom}, $urandom,
                            $urandom, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
                    2: query($urandom, $urandom, rand_set(), rand_set(),
                             $urandom_range(0, 1), $urandom_range(0, 1));
                    default:
                    begin
                        lo = (n > 0) ? sizes[$urandom_range(0, n - 1)] : $urandom;
                        lo = lo + $urandom_range(0, 60000) - 30000;
                        hi = lo + $urandom_range(0, 100000) - 20000;
                        query(lo, hi, rand_set(), rand_set(),
                              $urandom_range(0, 1), $urandom_range(0, 1));
                    end
                endcase
            end
            sent += 20;
        end
    endtask

    initial
    begin
        tbl_count = 0;
        drop_cost = DROP_WEIGHT_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty();
        test_directed();
        drain();
        test_drop_cost();
        test_full_table();
        test_random();
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
rtl/mscs_pkg.sv
rtl/mscs_datapath.sv
rtl/mscs_control.sv
rtl/moduli_subset_cost_select.sv
tb/sv/tb_moduli_subset_cost_select.sv
